[rtl/hdcp_pkg.sv]
package hdcp_pkg;

  // Keyword bytes kept in the result; longer keywords are rejected.
  localparam int unsigned KEYWORD_MAX = 8;
  // Bytes allowed before the terminator.
  localparam int unsigned MESSAGE_MAX = 254;

  localparam logic [7:0] CHAR_BANG   = 8'h21;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_PAREN  = 8'h29;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam logic [31:0] MAG_LIMIT  = 32'h8000_0000;
  localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] NUM_ABSENT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    PH_SKIP_KW    = 3'd0,
    PH_KEYWORD    = 3'd1,
    PH_SKIP_SEQ   = 3'd2,
    PH_SEQ_LEAD   = 3'd3,
    PH_SEQ_DIGITS = 3'd4,
    PH_SKIP_VAL   = 3'd5,
    PH_VAL_LEAD   = 3'd6,
    PH_VAL_DIGITS = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_TERMINATOR   = 3'd1,
    ERR_NO_KEYWORD   = 3'd2,
    ERR_TOO_LONG     = 3'd3,
    ERR_KEYWORD_LONG = 3'd4
  } err_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Append one decimal digit to a magnitude, saturating at 2^31.
  function automatic logic [31:0] add_digit(input logic [31:0] mag, input logic [7:0] c);
    logic [35:0] t;
    logic [7:0]  d;
    d = c - CHAR_ZERO;
    t = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + {28'b0, d};
    return (t > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : t[31:0];
  endfunction

  // Apply the sign to a magnitude, saturating positive values.
  function automatic logic [31:0] finish_number(input logic [31:0] mag, input logic neg);
    if (neg) begin
      return 32'd0 - mag;
    end
    return (mag >= MAG_LIMIT) ? POS_MAX : mag;
  endfunction

endpackage

[rtl/hash_delimited_command_parser.sv]
// Channel   Signals                               Moves
// input     in_valid, in_ready, msg_byte, is_final  one message byte per transaction
// output    out_valid, out_ready, rejected, ...     one parse result per final byte
//
// One byte per cycle while in_ready is high: token phase and number registers
// update on each accepted transaction through a single shared digit accumulator.
// A result is held in the output register the cycle after the final byte.
// in_ready stays high while the output register is empty or being taken.
// rst clears the phase, counters and output valid synchronously.
module hash_delimited_command_parser #(
  parameter int unsigned KEYWORD_MAX = hdcp_pkg::KEYWORD_MAX,
  parameter int unsigned MESSAGE_MAX = hdcp_pkg::MESSAGE_MAX
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         msg_byte,
  input  logic               is_final,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               rejected,
  output logic [2:0]         error_kind,
  output logic [63:0]        keyword_chars,
  output logic [3:0]         keyword_length,
  output logic signed [31:0] seq_number,
  output logic signed [31:0] value_number
);

  hdcp_pkg::phase_t token_phase, token_phase_next;
  logic [63:0] keyword_store, keyword_store_next;
  logic [3:0]  keyword_count, keyword_count_next;
  logic [31:0] seq_accum, seq_accum_next;
  logic [31:0] value_accum, value_accum_next;
  logic        number_negative, number_negative_next;
  logic        number_stopped, number_stopped_next;
  logic [7:0]  byte_count, byte_count_next;

  logic        in_fire;
  logic        kw_take;
  logic        is_hash;
  logic        is_paren;

  // Shared number unit
  logic        num_run, num_lead, num_is_val, num_adv;
  logic [31:0] acc_in, acc_out;
  logic        neg_in, neg_out, stop_in, stop_out;

  // Result
  hdcp_pkg::err_t res_err;
  logic [31:0] res_seq, res_val;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign is_hash  = (msg_byte == hdcp_pkg::CHAR_HASH);
  assign is_paren = (msg_byte == hdcp_pkg::CHAR_PAREN);

  // Select what the number unit works on for this byte
  always_comb begin
    num_run    = 1'b0;
    num_lead   = 1'b0;
    num_is_val = 1'b0;
    acc_in     = seq_accum;
    neg_in     = number_negative;
    stop_in    = number_stopped;
    kw_take    = 1'b0;
    unique case (token_phase)
      hdcp_pkg::PH_SKIP_KW, hdcp_pkg::PH_KEYWORD: begin
        kw_take = !is_hash;
      end
      hdcp_pkg::PH_SKIP_SEQ: begin
        num_run  = !is_hash;
        num_lead = 1'b1;
        acc_in   = 32'd0;
        neg_in   = 1'b0;
        stop_in  = 1'b0;
      end
      hdcp_pkg::PH_SEQ_LEAD, hdcp_pkg::PH_SEQ_DIGITS: begin
        num_run  = !is_hash;
        num_lead = (token_phase == hdcp_pkg::PH_SEQ_LEAD);
      end
      hdcp_pkg::PH_SKIP_VAL: begin
        num_run    = !is_paren;
        num_lead   = 1'b1;
        num_is_val = 1'b1;
        acc_in     = 32'd0;
        neg_in     = 1'b0;
        stop_in    = 1'b0;
      end
      hdcp_pkg::PH_VAL_LEAD, hdcp_pkg::PH_VAL_DIGITS: begin
        num_run    = !is_paren;
        num_lead   = (token_phase == hdcp_pkg::PH_VAL_LEAD);
        num_is_val = 1'b1;
        acc_in     = value_accum;
      end
      default: begin
        num_run = 1'b0;
      end
    endcase
  end

  // Skip leading whitespace, take a sign, then accumulate digits
  always_comb begin
    acc_out  = acc_in;
    neg_out  = neg_in;
    stop_out = stop_in;
    num_adv  = 1'b0;
    if (num_lead && hdcp_pkg::is_space(msg_byte)) begin
      num_adv = 1'b0;
    end else if (num_lead && (msg_byte == hdcp_pkg::CHAR_PLUS ||
                              msg_byte == hdcp_pkg::CHAR_MINUS)) begin
      num_adv = 1'b1;
      neg_out = (msg_byte == hdcp_pkg::CHAR_MINUS);
    end else begin
      num_adv = num_lead;
      if (!stop_in) begin
        if (hdcp_pkg::is_digit(msg_byte)) begin
          acc_out = hdcp_pkg::add_digit(acc_in, msg_byte);
        end else begin
          stop_out = 1'b1;
        end
      end
    end
  end

  // Next state for a non-final byte
  always_comb begin
    token_phase_next     = token_phase;
    keyword_store_next   = keyword_store;
    keyword_count_next   = keyword_count;
    seq_accum_next       = seq_accum;
    value_accum_next     = value_accum;
    number_negative_next = number_negative;
    number_stopped_next  = number_stopped;
    byte_count_next      = (byte_count == 8'hFF) ? byte_count : byte_count + 8'd1;

    // Keyword characters
    if (kw_take) begin
      for (int i = 0; i < 8; i++) begin
        if (keyword_count == 4'(i) && i < int'(KEYWORD_MAX)) begin
          keyword_store_next[i*8 +: 8] = msg_byte;
        end
      end
      if ({28'b0, keyword_count} <= KEYWORD_MAX) begin
        keyword_count_next = keyword_count + 4'd1;
      end
    end

    // Numeric tokens
    if (num_run) begin
      number_negative_next = neg_out;
      number_stopped_next  = stop_out;
      if (num_is_val) begin
        value_accum_next = acc_out;
      end else begin
        seq_accum_next = acc_out;
      end
    end

    unique case (token_phase)
      hdcp_pkg::PH_SKIP_KW: begin
        if (!is_hash) begin
          token_phase_next = hdcp_pkg::PH_KEYWORD;
        end
      end
      hdcp_pkg::PH_KEYWORD: begin
        if (is_hash) begin
          token_phase_next = hdcp_pkg::PH_SKIP_SEQ;
        end
      end
      hdcp_pkg::PH_SKIP_SEQ: begin
        if (!is_hash) begin
          token_phase_next = num_adv ? hdcp_pkg::PH_SEQ_DIGITS : hdcp_pkg::PH_SEQ_LEAD;
        end
      end
      hdcp_pkg::PH_SEQ_LEAD, hdcp_pkg::PH_SEQ_DIGITS: begin
        if (is_hash) begin
          seq_accum_next   = hdcp_pkg::finish_number(seq_accum, number_negative);
          token_phase_next = hdcp_pkg::PH_SKIP_VAL;
        end else if (num_adv) begin
          token_phase_next = hdcp_pkg::PH_SEQ_DIGITS;
        end
      end
      hdcp_pkg::PH_SKIP_VAL: begin
        if (!is_paren) begin
          token_phase_next = num_adv ? hdcp_pkg::PH_VAL_DIGITS : hdcp_pkg::PH_VAL_LEAD;
        end
      end
      hdcp_pkg::PH_VAL_LEAD, hdcp_pkg::PH_VAL_DIGITS: begin
        if (is_paren) begin
          token_phase_next    = hdcp_pkg::PH_VAL_DIGITS;
          number_stopped_next = 1'b1;
        end else if (num_adv) begin
          token_phase_next = hdcp_pkg::PH_VAL_DIGITS;
        end
      end
      default: begin
        token_phase_next = token_phase;
      end
    endcase
  end

  // Result for a final byte
  always_comb begin
    if (msg_byte != hdcp_pkg::CHAR_BANG) begin
      res_err = hdcp_pkg::ERR_TERMINATOR;
    end else if ({1'b0, byte_count} > 9'(MESSAGE_MAX)) begin
      res_err = hdcp_pkg::ERR_TOO_LONG;
    end else if (token_phase == hdcp_pkg::PH_SKIP_KW) begin
      res_err = hdcp_pkg::ERR_NO_KEYWORD;
    end else if ({28'b0, keyword_count} > KEYWORD_MAX) begin
      res_err = hdcp_pkg::ERR_KEYWORD_LONG;
    end else begin
      res_err = hdcp_pkg::ERR_NONE;
    end

    res_seq = hdcp_pkg::NUM_ABSENT;
    res_val = hdcp_pkg::NUM_ABSENT;
    if (token_phase == hdcp_pkg::PH_SEQ_LEAD || token_phase == hdcp_pkg::PH_SEQ_DIGITS) begin
      res_seq = hdcp_pkg::finish_number(seq_accum, number_negative);
    end else if (token_phase >= hdcp_pkg::PH_SKIP_VAL) begin
      res_seq = seq_accum;
    end
    if (token_phase >= hdcp_pkg::PH_VAL_LEAD) begin
      res_val = hdcp_pkg::finish_number(value_accum, number_negative);
    end
  end

  // Parser state: advance per byte, drop back to reset after the final byte
  always_ff @(posedge clk) begin
    if (rst || (in_fire && is_final)) begin
      token_phase     <= hdcp_pkg::PH_SKIP_KW;
      keyword_store   <= 64'd0;
      keyword_count   <= 4'd0;
      seq_accum       <= hdcp_pkg::NUM_ABSENT;
      value_accum     <= hdcp_pkg::NUM_ABSENT;
      number_negative <= 1'b0;
      number_stopped  <= 1'b0;
      byte_count      <= 8'd0;
    end else if (in_fire) begin
      token_phase     <= token_phase_next;
      keyword_store   <= keyword_store_next;
      keyword_count   <= keyword_count_next;
      seq_accum       <= seq_accum_next;
      value_accum     <= value_accum_next;
      number_negative <= number_negative_next;
      number_stopped  <= number_stopped_next;
      byte_count      <= byte_count_next;
    end
  end

  // Output valid: set on a final byte, clear when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && is_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload: hold until the next result
  always_ff @(posedge clk) begin
    if (in_fire && is_final) begin
      rejected   <= (res_err != hdcp_pkg::ERR_NONE);
      error_kind <= res_err;
      if (res_err != hdcp_pkg::ERR_NONE) begin
        keyword_chars  <= 64'd0;
        keyword_length <= 4'd0;
        seq_number     <= hdcp_pkg::NUM_ABSENT;
        value_number   <= hdcp_pkg::NUM_ABSENT;
      end else begin
        keyword_chars  <= keyword_store;
        keyword_length <= keyword_count;
        seq_number     <= res_seq;
        value_number   <= res_val;
      end
    end
  end

endmodule

[rtl/hdcp_checker.sv]
module hdcp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         msg_byte,
  input logic               is_final,
  input logic               out_valid,
  input logic               out_ready,
  input logic               rejected,
  input logic [2:0]         error_kind,
  input logic [63:0]        keyword_chars,
  input logic [3:0]         keyword_length,
  input logic signed [31:0] seq_number,
  input logic signed [31:0] value_number
);

  // Error flag agrees with the error code
  a_flag_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rejected == (error_kind != hdcp_pkg::ERR_NONE)))
    else $error("rejected disagrees with error_kind");

  // Rejected messages carry blank fields
  a_error_blanks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rejected) |-> (keyword_length == 4'd0 && keyword_chars == 64'd0 &&
                                 seq_number == -32'sd1 && value_number == -32'sd1))
    else $error("error result carries data");

  // Accepted messages have a keyword within the limit
  a_ok_keyword_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rejected) |-> (keyword_length != 4'd0 &&
                                  {28'b0, keyword_length} <= hdcp_pkg::KEYWORD_MAX))
    else $error("keyword length out of range on success");

  // Wrong terminator shows up as such in the next cycle
  a_bad_terminator: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && is_final && msg_byte != hdcp_pkg::CHAR_BANG) |=>
      (out_valid && error_kind == hdcp_pkg::ERR_TERMINATOR))
    else $error("bad terminator not reported");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(error_kind) &&
                                   $stable(keyword_chars) && $stable(seq_number) &&
                                   $stable(value_number)))
    else $error("stalled result changed");

endmodule

bind hash_delimited_command_parser hdcp_checker u_hdcp_checker (.*);

[tb/tb.sv]
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic       hold;
    logic       fin;
    logic [7:0] ch;
  } byte_item_t;

  typedef struct packed {
    logic           err_flag;
    hdcp_pkg::err_t kind;
    logic [63:0]    chars;
    logic [3:0]     klen;
    logic [31:0]    seq;
    logic [31:0]    val;
  } parse_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         msg_byte = 8'h21;
  logic               is_final = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               rejected;
  logic [2:0]         error_kind;
  logic [63:0]        keyword_chars;
  logic [3:0]         keyword_length;
  logic signed [31:0] seq_number;
  logic signed [31:0] value_number;

  hash_delimited_command_parser dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .msg_byte       (msg_byte),
    .is_final       (is_final),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .rejected       (rejected),
    .error_kind     (error_kind),
    .keyword_chars  (keyword_chars),
    .keyword_length (keyword_length),
    .seq_number     (seq_number),
    .value_number   (value_number)
  );

  // Toggle the clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_item_t    byte_stream[$];
  parse_result_t parse_results[$];

  int total_items = 0;
  int sent_count = 0;
  int finals_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycles = 0;
  int msg_bytes = 0;
  logic next_hold = 1'b0;

  // Parser shadow state
  hdcp_pkg::phase_t cur_phase;
  logic [63:0]      kw_bytes;
  logic [3:0]       kw_count;
  logic [31:0]      seq_mag;
  logic [31:0]      val_mag;
  logic             neg_flag;
  logic             stop_flag;
  logic [7:0]       msg_len;
  logic             len_over;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == hdcp_pkg::CHAR_SPACE) || (c >= hdcp_pkg::CHAR_TAB && c <= hdcp_pkg::CHAR_CR);
  endfunction

  function automatic logic decimal_char(input logic [7:0] c);
    return (c >= hdcp_pkg::CHAR_ZERO) && (c <= hdcp_pkg::CHAR_NINE);
  endfunction

  // Multiply by ten and add, clamping the magnitude at 2^31
  function automatic logic [31:0] append_digit(input logic [31:0] mag, input logic [7:0] c);
    logic [63:0] wide;
    wide = {32'd0, mag} * 64'd10 + {56'd0, c - hdcp_pkg::CHAR_ZERO};
    if (wide > {32'd0, hdcp_pkg::MAG_LIMIT}) return hdcp_pkg::MAG_LIMIT;
    return wide[31:0];
  endfunction

  function automatic logic [31:0] signed_result(input logic [31:0] mag, input logic neg);
    if (neg) return -mag;
    if (mag >= hdcp_pkg::MAG_LIMIT) return hdcp_pkg::POS_MAX;
    return mag;
  endfunction

  task automatic clear_parser();
    cur_phase = hdcp_pkg::PH_SKIP_KW;
    kw_bytes  = 64'd0;
    kw_count  = 4'd0;
    seq_mag   = hdcp_pkg::NUM_ABSENT;
    val_mag   = hdcp_pkg::NUM_ABSENT;
    neg_flag  = 1'b0;
    stop_flag = 1'b0;
    msg_len   = 8'd0;
    len_over  = 1'b0;
  endtask

  // Feed one character to a number token; lead covers blanks and sign
  task automatic digit_step(inout logic [31:0] acc, input logic [7:0] c, input logic lead);
    logic done;
    done = 1'b0;
    if (lead) begin
      if (blank_char(c)) begin
        done = 1'b1;
      end else begin
        cur_phase = hdcp_pkg::phase_t'(cur_phase + 3'd1);
        if (c == hdcp_pkg::CHAR_PLUS || c == hdcp_pkg::CHAR_MINUS) begin
          neg_flag = (c == hdcp_pkg::CHAR_MINUS);
          done = 1'b1;
        end
      end
    end
    if (!done && !stop_flag) begin
      if (decimal_char(c)) acc = append_digit(acc, c);
      else stop_flag = 1'b1;
    end
  endtask

  // Advance the tokenizer by one non-final byte
  task automatic absorb_char(input logic [7:0] c);
    if (msg_len < 8'd255) msg_len = msg_len + 8'd1;
    if (msg_len > hdcp_pkg::MESSAGE_MAX) len_over = 1'b1;
    case (cur_phase)
      hdcp_pkg::PH_SKIP_KW, hdcp_pkg::PH_KEYWORD: begin
        if (c == hdcp_pkg::CHAR_HASH) begin
          if (cur_phase == hdcp_pkg::PH_KEYWORD) cur_phase = hdcp_pkg::PH_SKIP_SEQ;
        end else begin
          cur_phase = hdcp_pkg::PH_KEYWORD;
          if (kw_count < hdcp_pkg::KEYWORD_MAX) kw_bytes[int'(kw_count) * 8 +: 8] = c;
          if (kw_count <= hdcp_pkg::KEYWORD_MAX) kw_count = kw_count + 4'd1;
        end
      end
      hdcp_pkg::PH_SKIP_SEQ: begin
        if (c != hdcp_pkg::CHAR_HASH) begin
          seq_mag   = 32'd0;
          neg_flag  = 1'b0;
          stop_flag = 1'b0;
          cur_phase = hdcp_pkg::PH_SEQ_LEAD;
          digit_step(seq_mag, c, 1'b1);
        end
      end
      hdcp_pkg::PH_SEQ_LEAD, hdcp_pkg::PH_SEQ_DIGITS: begin
        if (c == hdcp_pkg::CHAR_HASH) begin
          seq_mag   = signed_result(seq_mag, neg_flag);
          cur_phase = hdcp_pkg::PH_SKIP_VAL;
        end else begin
          digit_step(seq_mag, c, cur_phase == hdcp_pkg::PH_SEQ_LEAD);
        end
      end
      hdcp_pkg::PH_SKIP_VAL: begin
        if (c != hdcp_pkg::CHAR_PAREN) begin
          val_mag   = 32'd0;
          neg_flag  = 1'b0;
          stop_flag = 1'b0;
          cur_phase = hdcp_pkg::PH_VAL_LEAD;
          digit_step(val_mag, c, 1'b1);
        end
      end
      default: begin
        if (c == hdcp_pkg::CHAR_PAREN) begin
          cur_phase = hdcp_pkg::PH_VAL_DIGITS;
          stop_flag = 1'b1;
        end else begin
          digit_step(val_mag, c, cur_phase == hdcp_pkg::PH_VAL_LEAD);
        end
      end
    endcase
  endtask

  // Judge the terminator, queue the parse result, start over
  task automatic close_message(input logic [7:0] c);
    parse_result_t  r;
    hdcp_pkg::err_t e;
    logic [31:0]    seq;
    logic [31:0]    val;
    e   = hdcp_pkg::ERR_NONE;
    seq = hdcp_pkg::NUM_ABSENT;
    val = hdcp_pkg::NUM_ABSENT;
    if (c != hdcp_pkg::CHAR_BANG) e = hdcp_pkg::ERR_TERMINATOR;
    else if (len_over) e = hdcp_pkg::ERR_TOO_LONG;
    else if (cur_phase == hdcp_pkg::PH_SKIP_KW) e = hdcp_pkg::ERR_NO_KEYWORD;
    else if (kw_count > hdcp_pkg::KEYWORD_MAX) e = hdcp_pkg::ERR_KEYWORD_LONG;
    if (cur_phase == hdcp_pkg::PH_SEQ_LEAD || cur_phase == hdcp_pkg::PH_SEQ_DIGITS)
      seq = signed_result(seq_mag, neg_flag);
    else if (cur_phase >= hdcp_pkg::PH_SKIP_VAL)
      seq = seq_mag;
    if (cur_phase >= hdcp_pkg::PH_VAL_LEAD) val = signed_result(val_mag, neg_flag);
    r.err_flag = (e != hdcp_pkg::ERR_NONE);
    r.kind     = e;
    r.chars    = r.err_flag ? 64'd0 : kw_bytes;
    r.klen     = r.err_flag ? 4'd0 : kw_count;
    r.seq      = r.err_flag ? hdcp_pkg::NUM_ABSENT : seq;
    r.val      = r.err_flag ? hdcp_pkg::NUM_ABSENT : val;
    parse_results.push_back(r);
    clear_parser();
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // Stimulus helpers
  task automatic push_char(input logic [7:0] c);
    byte_item_t it;
    it.hold = next_hold;
    it.fin  = 1'b0;
    it.ch   = c;
    next_hold = 1'b0;
    msg_bytes++;
    byte_stream.push_back(it);
  endtask

  task automatic push_final(input logic [7:0] c);
    byte_item_t it;
    it.hold = next_hold;
    it.fin  = 1'b1;
    it.ch   = c;
    next_hold = 1'b0;
    byte_stream.push_back(it);
  endtask

  task automatic push_text(input string s, input logic [7:0] term);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i]);
    push_final(term);
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] pick;
    case ($urandom_range(7))
      0: pick = hdcp_pkg::CHAR_HASH;
      1: pick = hdcp_pkg::CHAR_PAREN;
      2: pick = hdcp_pkg::CHAR_BANG;
      3: pick = hdcp_pkg::CHAR_ZERO + 8'($urandom_range(9));
      default: pick = 8'($urandom_range(1, 255));
    endcase
    return pick;
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] pick;
    do pick = 8'($urandom_range(1, 255)); while (pick == hdcp_pkg::CHAR_HASH);
    return pick;
  endfunction

  function automatic logic [7:0] blank_pick();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? hdcp_pkg::CHAR_SPACE : hdcp_pkg::CHAR_TAB + 8'(r);
  endfunction

  // Blanks, an optional sign, digits, sometimes trailing junk
  task automatic push_number();
    int n;
    repeat ($urandom_range(0, 2)) push_char(blank_pick());
    case ($urandom_range(3))
      0: push_char(hdcp_pkg::CHAR_PLUS);
      1: push_char(hdcp_pkg::CHAR_MINUS);
      default: ;
    endcase
    n = ($urandom_range(3) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
    repeat (n) push_char(hdcp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) push_char(noise_char());
  endtask

  // Mostly well-formed commands, some cut short, some pure noise
  task automatic build_message(input int pad_to);
    int         kind;
    int         cut;
    int         n;
    logic [7:0] term;
    kind = $urandom_range(99);
    msg_bytes = 0;
    if (kind < 12) begin
      n = $urandom_range(0, 20);
      repeat (n) push_char(noise_char());
    end else begin
      cut = ($urandom_range(3) == 0) ? $urandom_range(0, 4) : 5;
      repeat ($urandom_range(0, 3)) push_char(hdcp_pkg::CHAR_HASH);
      n = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
      repeat (n) push_char(word_char());
      if (cut > 0) repeat ($urandom_range(1, 3)) push_char(hdcp_pkg::CHAR_HASH);
      if (cut > 1) push_number();
      if (cut > 2) begin
        push_char(hdcp_pkg::CHAR_HASH);
        repeat ($urandom_range(0, 2)) push_char(hdcp_pkg::CHAR_PAREN);
      end
      if (cut > 3) push_number();
      if (cut > 4 && $urandom_range(1) == 0) begin
        push_char(hdcp_pkg::CHAR_PAREN);
        repeat ($urandom_range(0, 3)) push_char(noise_char());
      end
    end
    while (msg_bytes < pad_to) push_char(noise_char());
    term = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : hdcp_pkg::CHAR_BANG;
    push_final(term);
  endtask

  // Driver: present queued bytes, hold until accepted, throttle both sides
  always @(posedge clk) begin
    byte_item_t head;
    int send_idle;
    int take_idle;
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        head = byte_stream.pop_front();
        if (head.fin) finals_sent++;
        sent_count++;
      end
      if (sent_count < total_items / 3) begin
        send_idle = 35;
        take_idle = 86;
      end else if (sent_count < 2 * total_items / 3) begin
        send_idle = 86;
        take_idle = 35;
      end else begin
        send_idle = 0;
        take_idle = 0;
      end
      if (!(in_valid && !in_ready)) begin
        if (byte_stream.size() != 0 &&
            !(byte_stream[0].hold && finals_sent != results_seen) &&
            $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          msg_byte <= byte_stream[0].ch;
          is_final <= byte_stream[0].fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= take_idle);
    end
  end

  // Monitor: predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      clear_parser();
    end else begin
      if (in_valid && in_ready) begin
        if (is_final) close_message(msg_byte);
        else absorb_char(msg_byte);
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (parse_results.size() == 0) begin
          flag_mismatch("result with nothing pending", 64'd0, 64'd0);
        end else begin
          want = parse_results.pop_front();
          if (rejected !== want.err_flag)
            flag_mismatch("rejected", {63'd0, rejected}, {63'd0, want.err_flag});
          if (error_kind !== want.kind)
            flag_mismatch("error_kind", {61'd0, error_kind}, {61'd0, want.kind});
          if (keyword_chars !== want.chars)
            flag_mismatch("keyword_chars", keyword_chars, want.chars);
          if (keyword_length !== want.klen)
            flag_mismatch("keyword_length", {60'd0, keyword_length}, {60'd0, want.klen});
          if (seq_number !== want.seq)
            flag_mismatch("seq_number", {32'd0, seq_number}, {32'd0, want.seq});
          if (value_number !== want.val)
            flag_mismatch("value_number", {32'd0, value_number}, {32'd0, want.val});
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int msg_index;
    int pad_to;
    // Directed: empty command, extreme bytes with a bad terminator,
    // saturating numbers with a hash and an inner bang in the value,
    // overlong keyword, keyword alone
    push_text("", hdcp_pkg::CHAR_BANG);
    push_char(8'hFF);
    push_final(8'h01);
    push_text("##k#-9999999999#)) 9999999999#!)7", hdcp_pkg::CHAR_BANG);
    push_text("ABCDEFGHI", hdcp_pkg::CHAR_BANG);
    push_text("kw", hdcp_pkg::CHAR_BANG);

    // Random commands; two sit right at the length boundary
    msg_index = 0;
    while (byte_stream.size() < 1650) begin
      next_hold = (msg_index % 16 == 8);
      if (msg_index == 20) pad_to = int'(hdcp_pkg::MESSAGE_MAX);
      else if (msg_index == 45) pad_to = int'(hdcp_pkg::MESSAGE_MAX) + 1;
      else if ($urandom_range(49) == 0) pad_to = $urandom_range(250, 258);
      else pad_to = 0;
      build_message(pad_to);
      msg_index++;
    end
    total_items = byte_stream.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain, then allow stray results to show up
    @(negedge clk);
    while (byte_stream.size() != 0 || in_valid || parse_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
